// ----- rtl/fpa_pkg.sv -----
// Shared types and constants for the fit partition allocator.
// No dependencies; imported by fpa_dp, fpa_ctrl and the top level.
package fpa_pkg;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // item field widths
    localparam int ACTION_W   = 1;
    localparam int INDEX_W    = 4;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int REMAIN_W   = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // configuration port
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // fit modes; anything else behaves as first fit
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_NOFIT  = 2'd2,
        ST_BADIDX = 2'd3
    } result_status_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic scan_start;
        logic issue;
        logic commit;
        logic push;
    } fpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic action;
        logic count_zero;
        logic issue_last;
        logic out_free;
    } fpa_stat_t;

endpackage

// ----- rtl/fpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fpa_dp.sv -----
// Datapath: configuration registers, capacity RAM with per-entry valid bits,
// scan comparator, result and output registers. Uses fpa_pkg and fpa_ram.
module fpa_dp
    import fpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpa_cmd_t              cmd,
    output fpa_stat_t             stat,
    input  logic [ACTION_W-1:0]   s_tuser,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int LW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int PAD_W = OUT_DATA_W - INDEX_W - REMAIN_W;

    logic [MODE_W-1:0]    fit_mode_reg;
    logic [COUNT_W-1:0]   block_count_reg;
    logic                 action_reg;
    logic [INDEX_W-1:0]   bidx_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [IDX_W-1:0]     issue_idx_reg;
    logic                 pipe_v_reg;
    logic                 vld_d_reg;
    logic [IDX_W-1:0]     idx_d_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [MAX_BLOCKS-1:0] valid_reg;
    result_status_t       res_status_reg;
    logic [INDEX_W-1:0]   res_index_reg;
    logic [REMAIN_W-1:0]  res_remain_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [REMAIN_W-1:0]  out_remain_reg;

    logic [CNT_W-1:0]     active_n;
    logic                 bidx_ok;
    logic [SIZE_BITS-1:0] rd_data;
    logic [SIZE_BITS-1:0] cur_cap;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic [SIZE_BITS-1:0] left;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;

    // counts above the table size saturate
    assign active_n = (CW'(block_count_reg) > CW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : CNT_W'(block_count_reg);
    assign bidx_ok  = LW'(bidx_reg) < LW'(active_n);

    // never-written entries read as zero through the valid bit
    assign cur_cap = vld_d_reg ? rd_data : '0;
    assign fits    = cur_cap >= req_reg;

    always_comb
    begin
        case (fit_mode_reg)
            FIT_WORST: better = cur_cap > best_reg;
            FIT_BEST:  better = cur_cap < best_reg;
            default:   better = 1'b0;
        endcase
    end

    assign take = pipe_v_reg && fits && (!found_reg || better);
    assign left = best_reg - req_reg;

    assign ram_we    = (cmd.load && bidx_ok) || (cmd.commit && found_reg);
    assign ram_waddr = cmd.load ? IDX_W'(bidx_reg) : pick_reg;
    assign ram_wdata = cmd.load ? req_reg : left;

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg),
        .rdata (rd_data)
    );

    assign stat.action     = action_reg;
    assign stat.count_zero = (active_n == '0);
    assign stat.issue_last = (CNT_W'(issue_idx_reg) == (active_n - CNT_W'(1)));
    assign stat.out_free   = !m_valid_reg || m_tready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= FIT_WORST;
            block_count_reg <= COUNT_RESET;
            pipe_v_reg      <= 1'b0;
            found_reg       <= 1'b0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FIT_MODE:    fit_mode_reg    <= cfg_wdata[MODE_W-1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_wdata[COUNT_W-1:0];
                    default:         ;
                endcase
            end
            pipe_v_reg <= cmd.issue;
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.push)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= s_tuser[0];
            bidx_reg   <= s_tdata[INDEX_W-1:0];
            req_reg    <= SIZE_BITS'(s_tdata[INDEX_W +: SIZE_W]);
        end
        if (cmd.scan_start)
        begin
            issue_idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            issue_idx_reg <= issue_idx_reg + IDX_W'(1);
        end
        if (cmd.issue)
        begin
            vld_d_reg <= valid_reg[issue_idx_reg];
            idx_d_reg <= issue_idx_reg;
        end
        if (take)
        begin
            pick_reg <= idx_d_reg;
            best_reg <= cur_cap;
        end
        if (cmd.load)
        begin
            if (bidx_ok)
            begin
                res_status_reg <= ST_LOADED;
                res_index_reg  <= bidx_reg;
                res_remain_reg <= REMAIN_W'(req_reg);
            end
            else
            begin
                res_status_reg <= ST_BADIDX;
                res_index_reg  <= '0;
                res_remain_reg <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (found_reg)
            begin
                res_status_reg <= ST_ALLOC;
                res_index_reg  <= INDEX_W'(pick_reg);
                res_remain_reg <= REMAIN_W'(left);
            end
            else
            begin
                res_status_reg <= ST_NOFIT;
                res_index_reg  <= '0;
                res_remain_reg <= '0;
            end
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_remain_reg <= res_remain_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_remain_reg, out_index_reg};

endmodule

// ----- rtl/fpa_ctrl.sv -----
// Controller state machine: sequences load, capacity scan, write-back and
// result hand-off. Uses fpa_pkg; drives the datapath by command struct.
module fpa_ctrl
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output fpa_cmd_t  cmd,
    input  fpa_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.accept     = s_tvalid && ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.action == ACT_LOAD)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = stat.count_zero ? S_COMMIT : S_SCAN;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                // one capacity read per cycle
                cmd.issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read still in the compare stage
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

// ----- rtl/fit_partition_allocator.sv -----
// Top level of the fit partition allocator: controller plus datapath.
// Depends on fpa_pkg, fpa_ctrl, fpa_dp (and fpa_ram below it).

// Keeps the free capacity of up to MAX_BLOCKS partitions in a RAM that reads
// as all zero after reset (per-entry valid bits, so no clearing pass). An
// input item with tuser 0 loads one partition's capacity; with tuser 1 it
// allocates: the first block_count partitions are scanned from index zero
// and the largest (worst fit), smallest (best fit) or first fitting one is
// picked, ties to the lowest index, and the request is subtracted from it.
// One item is handled at a time. A load steps through dispatch, load and
// result states; an allocate steps through dispatch, the scan, a drain state,
// commit and result, skipping the scan when the effective partition count is
// zero. The scan reads one capacity per cycle through the RAM's single read
// port. The result sits in an output register, so a new item may be
// accepted while the previous result waits to be taken; the result of that
// new item then waits until the output register is free.
module fit_partition_allocator
    import fpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // block_index [3:0], size [19:4], zero pad
    input  logic [ACTION_W-1:0]   s_tuser,   // action [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // chosen_index [3:0], remaining [19:4], zero pad
    output logic [STATUS_W-1:0]   m_tuser,   // status [1:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    fpa_cmd_t  cmd;
    fpa_stat_t stat;

    fpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // a result is only pushed into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!m_tvalid || m_tready))
        else $error("result pushed over a pending item");

    // one item at a time: no acceptance in the cycle after one
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in progress");

    // scan reads never overlap a capacity write
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.issue && (cmd.load || cmd.commit)))
        else $error("scan overlaps a RAM write");

    // results without a partition carry zero index and room
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NOFIT || m_tuser == ST_BADIDX))
            |-> (m_tdata[INDEX_W-1:0] == '0 && m_tdata[INDEX_W +: REMAIN_W] == '0))
        else $error("non-zero fields on a failed item");
`endif

endmodule
